/* hdl/csb_pkg.sv */
// Shared constants for the cursor sequence buffer: default depth, field widths, command and status codes.
package csb_pkg;

  localparam int unsigned DEPTH_DEF = 64;

  localparam int unsigned DATA_W = 64;
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned STAT_W = 2;

  localparam logic [CMD_W-1:0] CMD_START   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADVANCE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ATTACH  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOITEM = 2'd2;

endpackage

/* hdl/csb_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module csb_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hdl/cursor_sequence_buffer_core.sv */
// Cursor sequence buffer: ordered word store with a cursor, kept in one RAM.
// Ordered store of up to DEPTH 64-bit words with a cursor, one result word per command.
// Start, advance, query and any rejected command go from acceptance through S_RD
// and S_WAIT back to idle; the result is registered as S_WAIT ends. Insert and attach
// go through S_SHIFT, S_PUT, S_RD and S_WAIT, and remove through S_SHIFT, S_RD and
// S_WAIT; S_SHIFT moves the stored words at or after the insert position, or after the
// removed word. Moves are bound by the single RAM: each moved word costs one read and
// one write, the write of one word overlapping the read of the next, and the current
// word, if any, is read back at the end of every command. A result waiting at the output
// does not block acceptance of the next command; it only holds S_WAIT until taken.
module cursor_sequence_buffer_core #(
  parameter int unsigned DEPTH = csb_pkg::DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [csb_pkg::CMD_W-1:0]        command_i,
  input  logic [csb_pkg::DATA_W-1:0]       data_value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [csb_pkg::STAT_W-1:0]       status_o,
  output logic                             has_current_o,
  output logic [csb_pkg::DATA_W-1:0]       current_value_o,
  output logic [$clog2(DEPTH+1)-1:0]       item_count_o
);

  import csb_pkg::*;

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHIFT = 3'd1;
  localparam logic [2:0] S_PUT   = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  cursor_q, cursor_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  left_q, left_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic [AW-1:0]     waddr_q, waddr_d;
  logic              up_q, up_d;
  logic              put_q, put_d;
  logic              pend_q, pend_d;
  logic [STAT_W-1:0] stat_q, stat_d;
  logic [DATA_W-1:0] word_q, word_d;

  logic              out_valid_q, out_valid_d;
  logic [STAT_W-1:0] out_stat_q, out_stat_d;
  logic              out_has_q, out_has_d;
  logic [DATA_W-1:0] out_val_q, out_val_d;
  logic [CNT_W-1:0]  out_cnt_q, out_cnt_d;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  logic              in_acc;
  logic              cur_valid;
  logic              full;
  logic [CNT_W-1:0]  cur_p1;
  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  ins_pos;

  csb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata),
    .rd_en_i   (mem_re),
    .rd_addr_i (mem_raddr),
    .rd_data_o (mem_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign cur_valid  = (cursor_q < count_q);
  assign full       = (count_q >= CNT_W'(DEPTH));
  assign cur_p1     = cursor_q + CNT_W'(1);
  assign cnt_m1     = count_q - CNT_W'(1);

  always_comb begin
    state_d     = state_q;
    cursor_d    = cursor_q;
    count_d     = count_q;
    left_d      = left_q;
    ptr_d       = ptr_q;
    waddr_d     = waddr_q;
    up_d        = up_q;
    put_d       = put_q;
    pend_d      = pend_q;
    stat_d      = stat_q;
    word_d      = word_q;
    out_valid_d = out_valid_q;
    out_stat_d  = out_stat_q;
    out_has_d   = out_has_q;
    out_val_d   = out_val_q;
    out_cnt_d   = out_cnt_q;
    mem_we      = 1'b0;
    mem_waddr   = waddr_q;
    mem_wdata   = mem_rdata;
    mem_re      = 1'b0;
    mem_raddr   = ptr_q;
    ins_pos     = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          stat_d  = STAT_OK;
          state_d = S_RD;
          unique case (command_i)
            CMD_START: begin
              cursor_d = '0;
            end
            CMD_ADVANCE: begin
              if (cur_valid) begin
                cursor_d = cur_p1;
              end else begin
                stat_d = STAT_NOITEM;
              end
            end
            CMD_INSERT, CMD_ATTACH: begin
              if (full) begin
                stat_d = STAT_FULL;
              end else begin
                if (command_i == CMD_INSERT) begin
                  ins_pos = cur_valid ? cursor_q : '0;
                end else begin
                  ins_pos = cur_valid ? cur_p1 : count_q;
                end
                cursor_d = ins_pos;
                count_d  = count_q + CNT_W'(1);
                left_d   = count_q - ins_pos;
                ptr_d    = cnt_m1[AW-1:0];
                up_d     = 1'b1;
                put_d    = 1'b1;
                pend_d   = 1'b0;
                word_d   = data_value_i;
                state_d  = S_SHIFT;
              end
            end
            CMD_REMOVE: begin
              if (!cur_valid) begin
                stat_d = STAT_NOITEM;
              end else begin
                count_d = cnt_m1;
                left_d  = cnt_m1 - cursor_q;
                ptr_d   = cur_p1[AW-1:0];
                up_d    = 1'b0;
                put_d   = 1'b0;
                pend_d  = 1'b0;
                state_d = S_SHIFT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SHIFT: begin
        // write back the word read last cycle, read the next one
        if (pend_q) begin
          mem_we = 1'b1;
        end
        if (left_q != '0) begin
          mem_re  = 1'b1;
          pend_d  = 1'b1;
          waddr_d = up_q ? (ptr_q + AW'(1)) : (ptr_q - AW'(1));
          ptr_d   = up_q ? (ptr_q - AW'(1)) : (ptr_q + AW'(1));
          left_d  = left_q - CNT_W'(1);
        end else begin
          pend_d  = 1'b0;
          state_d = put_q ? S_PUT : S_RD;
        end
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = cursor_q[AW-1:0];
        mem_wdata = word_q;
        state_d   = S_RD;
      end
      S_RD: begin
        if (cur_valid) begin
          mem_re    = 1'b1;
          mem_raddr = cursor_q[AW-1:0];
        end
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_stat_d  = stat_q;
          out_has_d   = cur_valid;
          out_val_d   = cur_valid ? mem_rdata : '0;
          out_cnt_d   = count_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cursor_q    <= '0;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q     <= left_d;
    ptr_q      <= ptr_d;
    waddr_q    <= waddr_d;
    up_q       <= up_d;
    put_q      <= put_d;
    stat_q     <= stat_d;
    word_q     <= word_d;
    out_stat_q <= out_stat_d;
    out_has_q  <= out_has_d;
    out_val_q  <= out_val_d;
    out_cnt_q  <= out_cnt_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_stat_q;
  assign has_current_o   = out_has_q;
  assign current_value_o = out_val_q;
  assign item_count_o    = out_cnt_q;

`ifndef ASSERT_OFF
  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= count_q)
    else $error("cursor beyond stored count");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("stored count beyond depth");

  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write to the same entry in one cycle");

  a_shift_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT && left_q == '0) |=> (state_q == S_PUT || state_q == S_RD))
    else $error("shift did not end when no words were left");

  a_empty_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_current_o) |-> (current_value_o == '0))
    else $error("value reported without a current word");
`endif

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for cursor_sequence_buffer_core with a built-in sequence predictor.
`timescale 1ns / 1ps

module tb_top;
  import csb_pkg::*;

  localparam int unsigned SEQ_DEPTH = DEPTH_DEF;
  localparam int unsigned CNT_W     = $clog2(SEQ_DEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

  localparam int unsigned RANDOM_WORDS = 600;
  localparam int unsigned HOLD_AFTER   = 150;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 100;

  typedef enum logic [1:0] {PH_FILL, PH_DRAIN, PH_WALK, PH_NOISE} phase_e;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] word;
  } seq_item_t;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic              has_cur;
    logic [DATA_W-1:0] value;
    logic [CNT_W-1:0]  count;
  } seq_report_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                in_valid_i      = 1'b0;
  logic                in_ready_o;
  logic [CMD_W-1:0]    command_i       = CMD_QUERY;
  logic [DATA_W-1:0]   data_value_i    = '0;
  logic                out_valid_o;
  logic                out_ready_i     = 1'b0;
  logic [STAT_W-1:0]   status_o;
  logic                has_current_o;
  logic [DATA_W-1:0]   current_value_o;
  logic [CNT_W-1:0]    item_count_o;

  cursor_sequence_buffer_core #(
    .DEPTH(SEQ_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .data_value_i   (data_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .has_current_o  (has_current_o),
    .current_value_o(current_value_o),
    .item_count_o   (item_count_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  logic [DATA_W-1:0] seq_words [SEQ_DEPTH];
  int                seq_count  = 0;
  int                seq_cursor = 0;

  seq_item_t   pending_words [$];
  seq_report_t due_reports   [$];
  seq_item_t   next_item;

  int  total_words    = 0;
  int  words_accepted = 0;
  int  results_seen   = 0;
  int  fail_count     = 0;
  int  send_gap       = 0;
  int  recv_stall     = 0;
  bit  send_calm      = 1'b0;
  bit  recv_calm      = 1'b0;
  bit  hold_off       = 1'b0;
  logic in_taken      = 1'b0;

  function automatic seq_report_t apply_command(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] word);
    seq_report_t res;
    int          pos;
    int          k;
    bit          valid;
    res.status = STAT_OK;
    valid = seq_cursor < seq_count;
    case (cmd)
      CMD_START: seq_cursor = 0;
      CMD_ADVANCE: begin
        if (valid) seq_cursor++;
        else res.status = STAT_NOITEM;
      end
      CMD_INSERT, CMD_ATTACH: begin
        if (seq_count >= SEQ_DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          if (cmd == CMD_INSERT) pos = valid ? seq_cursor : 0;
          else pos = valid ? seq_cursor + 1 : seq_count;
          for (k = seq_count; k > pos; k--) seq_words[k] = seq_words[k-1];
          seq_words[pos] = word;
          seq_count++;
          seq_cursor = pos;
        end
      end
      CMD_REMOVE: begin
        if (!valid) begin
          res.status = STAT_NOITEM;
        end else begin
          for (k = seq_cursor; k + 1 < seq_count; k++) seq_words[k] = seq_words[k+1];
          seq_count--;
        end
      end
      default: ;
    endcase
    res.has_cur = seq_cursor < seq_count;
    res.value   = res.has_cur ? seq_words[seq_cursor] : '0;
    res.count   = seq_count[CNT_W-1:0];
    return res;
  endfunction

  function automatic int next_gap(bit calm);
    int r;
    r = $urandom_range(99, 0);
    if (calm || r < 70) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [DATA_W-1:0] pick_word();
    int r;
    r = $urandom_range(15, 0);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [CMD_W-1:0] pick_command(phase_e ph);
    int r;
    r = $urandom_range(99, 0);
    case (ph)
      PH_FILL: begin
        if (r < 45) return CMD_INSERT;
        if (r < 85) return CMD_ATTACH;
        if (r < 93) return CMD_START;
        return CMD_ADVANCE;
      end
      PH_DRAIN: begin
        if (r < 60) return CMD_REMOVE;
        if (r < 80) return CMD_START;
        if (r < 90) return CMD_ADVANCE;
        if (r < 95) return CMD_INSERT;
        return CMD_QUERY;
      end
      PH_WALK: begin
        if (r < 20) return CMD_START;
        if (r < 45) return CMD_ADVANCE;
        if (r < 58) return CMD_INSERT;
        if (r < 71) return CMD_ATTACH;
        if (r < 90) return CMD_REMOVE;
        return CMD_QUERY;
      end
      default: return logic'($urandom_range(7, 0)) ? 3'($urandom_range(7, 0))
                                                   : 3'($urandom_range(7, 0));
    endcase
  endfunction

  task automatic add_item(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] word);
    seq_item_t it;
    it.cmd  = cmd;
    it.word = word;
    pending_words.push_back(it);
  endtask

  task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // driver: new word at the falling edge once the previous one is taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (send_gap > 0 || pending_words.size() == 0) begin
        in_valid_i <= 1'b0;
        if (send_gap > 0) send_gap--;
      end else begin
        next_item = pending_words.pop_front();
        in_valid_i   <= 1'b1;
        command_i    <= next_item.cmd;
        data_value_i <= next_item.word;
        send_gap = next_gap(send_calm);
      end
    end
    if ($urandom_range(199, 0) == 0) send_calm = !send_calm;
  end

  // receiver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_off || recv_stall > 0) begin
      out_ready_i <= 1'b0;
      if (recv_stall > 0) recv_stall--;
    end else begin
      out_ready_i <= 1'b1;
      recv_stall = next_gap(recv_calm);
    end
    if ($urandom_range(199, 0) == 0) recv_calm = !recv_calm;
  end

  // long receiver hold-off so the block backs up
  initial begin
    wait (results_seen >= HOLD_AFTER);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // monitor: predict on input handshake, check on output handshake
  always @(posedge clk_i) begin
    seq_report_t want;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        due_reports.push_back(apply_command(command_i, data_value_i));
        words_accepted++;
      end
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (due_reports.size() == 0) begin
          $error("unexpected result word: status %0d count %0d", status_o, item_count_o);
          fail_count++;
        end else begin
          want = due_reports.pop_front();
          check_field("status", DATA_W'(want.status), DATA_W'(status_o));
          check_field("has_current", DATA_W'(want.has_cur), DATA_W'(has_current_o));
          check_field("current_value", want.value, current_value_o);
          check_field("item_count", DATA_W'(want.count), DATA_W'(item_count_o));
        end
      end
    end
  end

  initial begin
    phase_e ph;
    int     len;
    int     n;
    // directed
    add_item(CMD_QUERY, '0);
    add_item(CMD_ADVANCE, '1);
    add_item(CMD_REMOVE, '0);
    add_item(CMD_START, '0);
    add_item(CMD_INSERT, '1);                      // empty: goes to front
    add_item(CMD_ADVANCE, '0);                     // steps off the last word
    add_item(CMD_ATTACH, '0);                      // no current: goes to end
    add_item(CMD_INSERT, 64'h5555_5555_5555_5555);
    add_item(CMD_ATTACH, 64'hAAAA_AAAA_AAAA_AAAA);
    add_item(CMD_START, '0);
    add_item(CMD_ADVANCE, '0);
    add_item(CMD_REMOVE, '0);                      // middle word
    add_item(CMD_ADVANCE, '0);
    add_item(CMD_REMOVE, '0);                      // last word: cursor off
    add_item(CMD_INSERT, 64'h0123_4567_89AB_CDEF); // no current: front
    add_item(CMD_SPARE6, 64'hFEDC_BA98_7654_3210);
    add_item(CMD_SPARE7, '1);
    add_item(CMD_REMOVE, '0);                      // front word
    add_item(CMD_START, '0);
    add_item(CMD_REMOVE, '0);
    add_item(CMD_REMOVE, '0);                      // now empty
    add_item(CMD_QUERY, '1);
    // random phases; first fill past full, then drain
    n = 0;
    ph = PH_FILL;
    len = 100;
    while (n < RANDOM_WORDS) begin
      repeat (len) begin
        add_item(pick_command(ph), pick_word());
        n++;
      end
      if (n == 100) begin
        ph = PH_DRAIN;
        len = 100;
      end else begin
        ph = phase_e'($urandom_range(3, 0));
        len = $urandom_range(80, 20);
      end
    end
    total_words = pending_words.size();

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (words_accepted == total_words);
    wait (due_reports.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("cursor_sequence_buffer_core regression: pass");
    end else begin
      $display("cursor_sequence_buffer_core regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("cursor_sequence_buffer_core regression: fail");
    $finish;
  end

endmodule
